FILE: hdl/fnps_pkg.sv
package fnps_pkg;

  // default parameter values
  localparam int unsigned LIST_DEPTH_DEF    = 10;
  localparam int unsigned REF_DIV_MIN_DEF   = 1;
  localparam int unsigned MAX_OUT_DIV_DEF   = 16;
  localparam int unsigned ERR_FRAC_BITS_DEF = 16;

  // fixed sizes
  localparam int unsigned HZ_PER_MHZ  = 1000000;
  localparam int unsigned OD_SLOTS    = 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned KEPT_W      = 5;
  localparam int unsigned DVD_W       = 64;
  localparam int unsigned DVS_W       = 32;
  localparam int unsigned ERR_W       = 48;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_DIV_MAX = 3'd0,
    REG_INT_MIN     = 3'd1,
    REG_INT_MAX     = 3'd2,
    REG_MOD_MAX     = 3'd3,
    REG_REF_MHZ     = 3'd4,
    REG_VCO_MIN     = 3'd5,
    REG_VCO_MAX     = 3'd6,
    REG_GOOD_ERR    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [9:0]  ref_div_max;
    logic [15:0] int_min;
    logic [15:0] int_max;
    logic [11:0] mod_max;
    logic [7:0]  ref_mhz;
    logic [12:0] vco_min_mhz;
    logic [12:0] vco_max_mhz;
    logic [19:0] good_err_hz;
  } cfg_t;

  // one queued request with its divider classification
  typedef struct packed {
    logic [31:0]         target_hz;
    logic [3:0]          rank;
    logic [OD_SLOTS-1:0] vco_ok;
  } req_t;

  // one ranked pll setting
  typedef struct packed {
    logic [15:0]      int_value;
    logic [11:0]      frac_value;
    logic [11:0]      modulus;
    logic [9:0]       ref_div;
    logic [2:0]       out_div_log2;
    logic [7:0]       band_div;
    logic [ERR_W-1:0] freq_error;
  } setting_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DVS_W-1:0] remainder;
  } div_rsp_t;

  typedef struct packed {
    logic     clear;
    logic     ins;
    setting_t entry;
  } list_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [KEPT_W-1:0] kept;
  } list_stat_t;

endpackage

FILE: hdl/fnps_div.sv
module fnps_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fnps_pkg::div_req_t req_i,
  output fnps_pkg::div_rsp_t rsp_o
);
  import fnps_pkg::*;

  localparam int unsigned CntW = $clog2(DVD_W);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
    end else if (run_q) begin
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

FILE: hdl/fnps_front.sv
module fnps_front #(
  parameter int unsigned MAX_OUT_DIV = fnps_pkg::MAX_OUT_DIV_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fnps_pkg::cfg_t cfg_i,
  input  logic           start,
  input  logic [31:0]    target_hz_i,
  input  logic [3:0]     rank_i,
  output logic           busy,
  output logic           req_valid_o,
  output fnps_pkg::req_t req_o,
  input  logic           req_pop_i
);
  import fnps_pkg::*;

  localparam int unsigned NumOd = $clog2(MAX_OUT_DIV + 1);
  localparam int unsigned PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);

  req_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic [32:0]     vmin, vmax;
  logic [37:0]     vco [OD_SLOTS];
  req_t            new_req;

  // vco window check for every output divider
  assign vmin = 33'(cfg_i.vco_min_mhz * 20'(HZ_PER_MHZ));
  assign vmax = 33'(cfg_i.vco_max_mhz * 20'(HZ_PER_MHZ));

  always_comb begin
    new_req.target_hz = target_hz_i;
    new_req.rank      = rank_i;
    for (int k = 0; k < OD_SLOTS; k++) begin
      vco[k] = {6'd0, target_hz_i} << k;
      new_req.vco_ok[k] = (k < NumOd) && (vco[k] >= {5'd0, vmin}) &&
                          (vco[k] <= {5'd0, vmax});
    end
  end

  // request queue
  assign busy        = cnt_q == CntW'(QUEUE_DEPTH);
  assign push        = start && !busy;
  assign req_valid_o = cnt_q != '0;
  assign req_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (req_pop_i) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !req_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && req_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= new_req;
    end
  end

endmodule

FILE: hdl/fnps_rank.sv
module fnps_rank #(
  parameter int unsigned LIST_DEPTH    = fnps_pkg::LIST_DEPTH_DEF,
  parameter int unsigned ERR_FRAC_BITS = fnps_pkg::ERR_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [19:0]          good_err_hz_i,
  input  fnps_pkg::list_cmd_t  cmd_i,
  input  logic [3:0]           rank_i,
  output fnps_pkg::list_stat_t stat_o,
  output fnps_pkg::setting_t   sel_o
);
  import fnps_pkg::*;

  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned PosW = $clog2(LIST_DEPTH + 1);

  setting_t              ent_q [LIST_DEPTH];
  setting_t              ent_d [LIST_DEPTH];
  setting_t              new_q;
  logic [LIST_DEPTH-1:0] beat_q, beat_d;
  logic                  cmp_q, ins_q;
  logic [KEPT_W-1:0]     kept_q, kept_d;
  logic [PosW-1:0]       pos;
  logic [ERR_W-1:0]      thresh;
  logic                  both_good;
  logic [KEPT_W-1:0]     sel_idx;

  assign thresh = ERR_W'(good_err_hz_i) << ERR_FRAC_BITS;

  // compare the new setting against every kept one
  always_comb begin
    both_good = 1'b0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      both_good = (new_q.freq_error < thresh) && (ent_q[i].freq_error < thresh);
      if (both_good && (new_q.modulus != ent_q[i].modulus)) begin
        beat_d[i] = new_q.modulus > ent_q[i].modulus;
      end else begin
        beat_d[i] = new_q.freq_error < ent_q[i].freq_error;
      end
      beat_d[i] = beat_d[i] && (KEPT_W'(i) < kept_q);
    end
  end

  // first kept entry beaten, else the end of the list
  always_comb begin
    pos = PosW'(kept_q);
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (beat_q[i]) begin
        pos = PosW'(i);
      end
    end
  end

  // insert and shift the tail down
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ent_d[i] = ent_q[i];
      if (ins_q && (pos < PosW'(LIST_DEPTH))) begin
        if (PosW'(i) == pos) begin
          ent_d[i] = new_q;
        end else if ((PosW'(i) > pos) && (i > 0)) begin
          ent_d[i] = ent_q[(i > 0) ? i - 1 : 0];
        end
      end
    end
    kept_d = kept_q;
    if (cmd_i.clear) begin
      kept_d = '0;
    end else if (ins_q && (pos < PosW'(LIST_DEPTH)) &&
                 (kept_q < KEPT_W'(LIST_DEPTH))) begin
      kept_d = kept_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_q  <= 1'b0;
      ins_q  <= 1'b0;
      kept_q <= '0;
    end else begin
      cmp_q  <= cmd_i.ins && !cmd_i.clear;
      ins_q  <= cmp_q && !cmd_i.clear;
      kept_q <= kept_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins) begin
      new_q <= cmd_i.entry;
    end
    beat_q <= beat_d;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  // rank past the end returns the last kept entry
  assign sel_idx = ({1'b0, rank_i} >= kept_q) ? kept_q - 1'b1 : KEPT_W'(rank_i);
  assign sel_o   = ent_q[sel_idx[IdxW-1:0]];

  assign stat_o.busy = cmp_q || ins_q;
  assign stat_o.kept = kept_q;

endmodule

FILE: hdl/fnps_back.sv
module fnps_back #(
  parameter int unsigned REF_DIV_MIN   = fnps_pkg::REF_DIV_MIN_DEF,
  parameter int unsigned MAX_OUT_DIV   = fnps_pkg::MAX_OUT_DIV_DEF,
  parameter int unsigned ERR_FRAC_BITS = fnps_pkg::ERR_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fnps_pkg::cfg_t       cfg_i,
  input  logic                 req_valid_i,
  input  fnps_pkg::req_t       req_i,
  output logic                 req_pop_o,
  output fnps_pkg::div_req_t   div_req_o,
  input  fnps_pkg::div_rsp_t   div_rsp_i,
  output fnps_pkg::list_cmd_t  list_cmd_o,
  input  fnps_pkg::list_stat_t list_stat_i,
  input  fnps_pkg::setting_t   sel_i,
  output logic [3:0]           rank_o,
  output logic                 strobe,
  output fnps_pkg::setting_t   result_o,
  output logic [3:0]           found_count_o
);
  import fnps_pkg::*;

  localparam int unsigned NumOd = $clog2(MAX_OUT_DIV + 1);
  localparam int unsigned LgW   = $clog2(NumOd + 1);
  localparam int unsigned RcW   = 11;
  localparam int unsigned PW    = 48;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'b0000_0000_0000_0001,
    ST_OD    = 16'b0000_0000_0000_0010,
    ST_RC    = 16'b0000_0000_0000_0100,
    ST_BAND  = 16'b0000_0000_0000_1000,
    ST_NDIV  = 16'b0000_0000_0001_0000,
    ST_CF    = 16'b0000_0000_0010_0000,
    ST_CFDIV = 16'b0000_0000_0100_0000,
    ST_CFMUL = 16'b0000_0000_1000_0000,
    ST_CHK   = 16'b0000_0001_0000_0000,
    ST_IL    = 16'b0000_0010_0000_0000,
    ST_EA    = 16'b0000_0100_0000_0000,
    ST_EB    = 16'b0000_1000_0000_0000,
    ST_EW    = 16'b0001_0000_0000_0000,
    ST_EF    = 16'b0010_0000_0000_0000,
    ST_INS   = 16'b0100_0000_0000_0000,
    ST_DONE  = 16'b1000_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // request and loop registers
  logic [31:0]      target_q, target_d;
  logic [3:0]       rank_q, rank_d;
  logic [NumOd-1:0] mask_q, mask_d;
  logic [27:0]      den_q, den_d;
  logic [LgW-1:0]   lg_q, lg_d;
  logic [RcW-1:0]   rc_q, rc_d;
  logic [7:0]       band_q, band_d;
  logic [63:0]      n_q, n_d;

  // continued fraction registers
  logic [PW-1:0]    p1_q, p1_d, p2_q, p2_d, pr_q, pr_d;
  logic [11:0]      q1_q, q1_d, q2_q, q2_d, qr_q, qr_d, qn_q, qn_d;
  logic [31:0]      d_q, d_d, r_q, r_d, nr_q, nr_d;

  // error registers
  logic [15:0]      il_q, il_d;
  logic [11:0]      frac_q, frac_d;
  logic [31:0]      d2_q, d2_d;
  logic [63:0]      ea_q, ea_d;
  logic [PW-1:0]    whole_q, whole_d;

  // result registers
  logic             strobe_q, strobe_d;
  setting_t         res_q, res_d;
  logic [3:0]       found_q, found_d;

  // shared shift-and-add multiplier, 8 bits of b per cycle
  logic             mul_start, mul_run_q, mul_done_q;
  logic [63:0]      mul_a, mul_a_q;
  logic [31:0]      mul_b, mul_b_q;
  logic [63:0]      acc_q;
  logic [1:0]       mcnt_q;
  logic [71:0]      pp;

  logic [27:0]      den_new;
  logic [63:0]      n_new;
  logic [31:0]      d2_new;
  logic [43:0]      qn_new;
  logic [PW-1:0]    p_new;
  logic [63:0]      diff;
  logic [NumOd-1:0] mask_sh;
  logic [63:0]      quo;
  logic [31:0]      rem;

  assign quo     = div_rsp_i.quotient;
  assign rem     = div_rsp_i.remainder;
  assign den_new = 28'({20'd0, cfg_i.ref_mhz} * 28'(HZ_PER_MHZ));
  assign n_new   = ({32'd0, target_q} * {53'd0, rc_q}) << lg_q;
  assign d2_new  = 32'(({11'd0, qr_q} * {12'd0, rc_q}) << lg_q);
  assign qn_new  = 44'({12'd0, quo[31:0]} * {32'd0, q1_q}) + {32'd0, q2_q};
  assign p_new   = acc_q[PW-1:0] + p2_q;
  assign diff    = (ea_q > acc_q) ? ea_q - acc_q : acc_q - ea_q;
  assign mask_sh = mask_q >> lg_q;
  assign pp      = mul_a_q * mul_b_q[7:0];

  // sequencer
  always_comb begin
    state_d   = state_q;
    target_d  = target_q;
    rank_d    = rank_q;
    mask_d    = mask_q;
    den_d     = den_q;
    lg_d      = lg_q;
    rc_d      = rc_q;
    band_d    = band_q;
    n_d       = n_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    pr_d      = pr_q;
    q1_d      = q1_q;
    q2_d      = q2_q;
    qr_d      = qr_q;
    qn_d      = qn_q;
    d_d       = d_q;
    r_d       = r_q;
    nr_d      = nr_q;
    il_d      = il_q;
    frac_d    = frac_q;
    d2_d      = d2_q;
    ea_d      = ea_q;
    whole_d   = whole_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    found_d   = found_q;
    req_pop_o = 1'b0;
    div_req_o = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    list_cmd_o = '0;
    list_cmd_o.entry.ref_div      = rc_q[9:0];
    list_cmd_o.entry.out_div_log2 = 3'(lg_q);
    list_cmd_o.entry.band_div     = band_q;
    list_cmd_o.entry.int_value    = il_q;
    list_cmd_o.entry.frac_value   = frac_q;
    list_cmd_o.entry.modulus      = qr_q;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o        = 1'b1;
          target_d         = req_i.target_hz;
          rank_d           = req_i.rank;
          mask_d           = req_i.vco_ok[NumOd-1:0];
          den_d            = den_new;
          lg_d             = '0;
          list_cmd_o.clear = 1'b1;
          state_d          = (cfg_i.ref_mhz == '0) ? ST_DONE : ST_OD;
        end
      end
      ST_OD: begin
        if (lg_q == LgW'(NumOd)) begin
          state_d = ST_DONE;
        end else if (mask_sh[0]) begin
          rc_d    = RcW'(REF_DIV_MIN);
          state_d = ST_RC;
        end else begin
          lg_d = lg_q + 1'b1;
        end
      end
      ST_RC: begin
        if (rc_q > {1'b0, cfg_i.ref_div_max}) begin
          lg_d    = lg_q + 1'b1;
          state_d = ST_OD;
        end else begin
          n_d                = n_new;
          div_req_o.start    = 1'b1;
          div_req_o.dividend = 64'({cfg_i.ref_mhz, 3'd0} + {3'd0, cfg_i.ref_mhz, 1'b0});
          div_req_o.divisor  = 32'(rc_q);
          state_d            = ST_BAND;
        end
      end
      ST_BAND: begin
        if (div_rsp_i.done) begin
          if (quo == '0) begin
            band_d = 8'd1;
          end else if (quo > 64'd255) begin
            band_d = 8'd255;
          end else begin
            band_d = quo[7:0];
          end
          div_req_o.start    = 1'b1;
          div_req_o.dividend = n_q;
          div_req_o.divisor  = 32'(den_q);
          state_d            = ST_NDIV;
        end
      end
      ST_NDIV: begin
        if (div_rsp_i.done) begin
          if ((rem == '0) && (quo >= 64'(cfg_i.int_min)) &&
              (quo <= 64'(cfg_i.int_max))) begin
            // exact integer mode
            list_cmd_o.ins                 = 1'b1;
            list_cmd_o.entry.int_value     = quo[15:0];
            list_cmd_o.entry.frac_value    = '0;
            list_cmd_o.entry.modulus       = cfg_i.mod_max;
            list_cmd_o.entry.freq_error    = '0;
            state_d                        = ST_INS;
          end else begin
            p1_d    = quo[PW-1:0];
            pr_d    = quo[PW-1:0];
            q1_d    = 12'd1;
            qr_d    = 12'd1;
            p2_d    = PW'(1);
            q2_d    = '0;
            d_d     = 32'(den_q);
            r_d     = rem;
            state_d = ST_CF;
          end
        end
      end
      ST_CF: begin
        if (r_q == '0) begin
          state_d = ST_CHK;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = 64'(d_q);
          div_req_o.divisor  = r_q;
          state_d            = ST_CFDIV;
        end
      end
      ST_CFDIV: begin
        if (div_rsp_i.done) begin
          nr_d = rem;
          if (qn_new > 44'(cfg_i.mod_max)) begin
            state_d = ST_CHK;
          end else begin
            qn_d      = qn_new[11:0];
            mul_start = 1'b1;
            mul_a     = 64'(p1_q);
            mul_b     = quo[31:0];
            state_d   = ST_CFMUL;
          end
        end
      end
      ST_CFMUL: begin
        if (mul_done_q) begin
          pr_d    = p_new;
          qr_d    = qn_q;
          p2_d    = p1_q;
          p1_d    = p_new;
          q2_d    = q1_q;
          q1_d    = qn_q;
          d_d     = r_q;
          r_d     = nr_q;
          state_d = ST_CF;
        end
      end
      ST_CHK: begin
        if ((qr_q < 12'd2) || (qr_q > cfg_i.mod_max)) begin
          rc_d    = rc_q + 1'b1;
          state_d = ST_RC;
        end else begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = 64'(pr_q);
          div_req_o.divisor  = 32'(qr_q);
          state_d            = ST_IL;
        end
      end
      ST_IL: begin
        if (div_rsp_i.done) begin
          if ((quo < 64'(cfg_i.int_min)) || (quo > 64'(cfg_i.int_max))) begin
            rc_d    = rc_q + 1'b1;
            state_d = ST_RC;
          end else begin
            il_d      = quo[15:0];
            frac_d    = rem[11:0];
            d2_d      = d2_new;
            mul_start = 1'b1;
            mul_a     = 64'(pr_q);
            mul_b     = 32'(den_q);
            state_d   = ST_EA;
          end
        end
      end
      ST_EA: begin
        if (mul_done_q) begin
          ea_d      = acc_q;
          mul_start = 1'b1;
          mul_a     = 64'(d2_q);
          mul_b     = target_q;
          state_d   = ST_EB;
        end
      end
      ST_EB: begin
        if (mul_done_q) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = diff;
          div_req_o.divisor  = d2_q;
          state_d            = ST_EW;
        end
      end
      ST_EW: begin
        if (div_rsp_i.done) begin
          if ((quo >> (ERR_W - ERR_FRAC_BITS)) != '0) begin
            list_cmd_o.ins              = 1'b1;
            list_cmd_o.entry.freq_error = ERR_MAX;
            state_d                     = ST_INS;
          end else begin
            whole_d            = quo[PW-1:0];
            div_req_o.start    = 1'b1;
            div_req_o.dividend = 64'(rem) << ERR_FRAC_BITS;
            div_req_o.divisor  = d2_q;
            state_d            = ST_EF;
          end
        end
      end
      ST_EF: begin
        if (div_rsp_i.done) begin
          list_cmd_o.ins              = 1'b1;
          list_cmd_o.entry.freq_error = ERR_W'(whole_q << ERR_FRAC_BITS) +
                                        quo[ERR_W-1:0];
          state_d                     = ST_INS;
        end
      end
      ST_INS: begin
        if (!list_stat_i.busy) begin
          rc_d    = rc_q + 1'b1;
          state_d = ST_RC;
        end
      end
      ST_DONE: begin
        if (!list_stat_i.busy) begin
          strobe_d = 1'b1;
          found_d  = list_stat_i.kept[3:0];
          res_d    = (list_stat_i.kept == '0) ? '0 : sel_i;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      strobe_q   <= 1'b0;
      mul_run_q  <= 1'b0;
      mul_done_q <= 1'b0;
      mcnt_q     <= '0;
    end else begin
      state_q    <= state_d;
      strobe_q   <= strobe_d;
      mul_done_q <= 1'b0;
      if (mul_start) begin
        mul_run_q <= 1'b1;
        mcnt_q    <= '0;
      end else if (mul_run_q) begin
        mcnt_q <= mcnt_q + 1'b1;
        if (mcnt_q == 2'd3) begin
          mul_run_q  <= 1'b0;
          mul_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    rank_q   <= rank_d;
    mask_q   <= mask_d;
    den_q    <= den_d;
    lg_q     <= lg_d;
    rc_q     <= rc_d;
    band_q   <= band_d;
    n_q      <= n_d;
    p1_q     <= p1_d;
    p2_q     <= p2_d;
    pr_q     <= pr_d;
    q1_q     <= q1_d;
    q2_q     <= q2_d;
    qr_q     <= qr_d;
    qn_q     <= qn_d;
    d_q      <= d_d;
    r_q      <= r_d;
    nr_q     <= nr_d;
    il_q     <= il_d;
    frac_q   <= frac_d;
    d2_q     <= d2_d;
    ea_q     <= ea_d;
    whole_q  <= whole_d;
    res_q    <= res_d;
    found_q  <= found_d;
    // multiplier datapath
    if (mul_start) begin
      mul_a_q <= mul_a;
      mul_b_q <= mul_b;
      acc_q   <= '0;
    end else if (mul_run_q) begin
      acc_q   <= acc_q + pp[63:0];
      mul_a_q <= mul_a_q << 8;
      mul_b_q <= mul_b_q >> 8;
    end
  end

  assign rank_o        = rank_q;
  assign strobe        = strobe_q;
  assign result_o      = res_q;
  assign found_count_o = found_q;

endmodule

FILE: hdl/frac_n_pll_setting_search.sv
// Fractional-N PLL setting search.
// Configuration: write cfg_wdata_i into register cfg_idx_i while cfg_we_i is
// high; values take effect for the next request. Writes are taken at any
// time but belong between requests.
// Request: target_hz_i and rank_i are taken at a rising edge with start high
// and busy low. Two requests can wait in the input queue; busy is high while
// it is full.
// Result: one item per request, on the result ports for exactly one cycle
// with strobe high. found_count_o of zero means no setting, all other fields
// then read zero. Results leave in request order.
// Search order: each in-range output divider scans every reference divider
// R; one R takes the band and quotient divisions, then, unless the quotient
// is an exact integer in range, a division and a multiplication per
// continued-fraction step, a division for the integer part and the
// multiplications and divisions for the error term. All of these run on the
// shared radix-2 divider and the shared multiplier.
// Reset clears the queue, the ranked list and the sequencer, and loads the
// register defaults. The receiver has no stall; the strobe is never held.
module frac_n_pll_setting_search #(
  parameter int unsigned LIST_DEPTH    = fnps_pkg::LIST_DEPTH_DEF,
  parameter int unsigned REF_DIV_MIN   = fnps_pkg::REF_DIV_MIN_DEF,
  parameter int unsigned MAX_OUT_DIV   = fnps_pkg::MAX_OUT_DIV_DEF,
  parameter int unsigned ERR_FRAC_BITS = fnps_pkg::ERR_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fnps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fnps_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            start,
  output logic                            busy,
  input  logic [31:0]                     target_hz_i,
  input  logic [3:0]                      rank_i,
  output logic                            strobe,
  output logic [15:0]                     int_value_o,
  output logic [11:0]                     frac_value_o,
  output logic [11:0]                     modulus_o,
  output logic [9:0]                      ref_div_o,
  output logic [2:0]                      out_div_log2_o,
  output logic [7:0]                      band_div_o,
  output logic [47:0]                     freq_error_o,
  output logic [3:0]                      found_count_o
);
  import fnps_pkg::*;

  cfg_t       cfg_q;
  logic       req_valid, req_pop;
  req_t       req;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  list_cmd_t  list_cmd;
  list_stat_t list_stat;
  setting_t   sel, result;
  logic [3:0] rank_sel;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_div_max <= 10'd1023;
      cfg_q.int_min     <= 16'd23;
      cfg_q.int_max     <= 16'd65535;
      cfg_q.mod_max     <= 12'd4095;
      cfg_q.ref_mhz     <= 8'd5;
      cfg_q.vco_min_mhz <= 13'd2200;
      cfg_q.vco_max_mhz <= 13'd4400;
      cfg_q.good_err_hz <= 20'd50;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_REF_DIV_MAX: cfg_q.ref_div_max <= cfg_wdata_i[9:0];
        REG_INT_MIN:     cfg_q.int_min     <= cfg_wdata_i[15:0];
        REG_INT_MAX:     cfg_q.int_max     <= cfg_wdata_i[15:0];
        REG_MOD_MAX:     cfg_q.mod_max     <= cfg_wdata_i[11:0];
        REG_REF_MHZ:     cfg_q.ref_mhz     <= cfg_wdata_i[7:0];
        REG_VCO_MIN:     cfg_q.vco_min_mhz <= cfg_wdata_i[12:0];
        REG_VCO_MAX:     cfg_q.vco_max_mhz <= cfg_wdata_i[12:0];
        REG_GOOD_ERR:    cfg_q.good_err_hz <= cfg_wdata_i[19:0];
        default: begin
        end
      endcase
    end
  end

  // request intake and queue
  fnps_front #(
    .MAX_OUT_DIV(MAX_OUT_DIV)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start       (start),
    .target_hz_i (target_hz_i),
    .rank_i      (rank_i),
    .busy        (busy),
    .req_valid_o (req_valid),
    .req_o       (req),
    .req_pop_i   (req_pop)
  );

  // search sequencer
  fnps_back #(
    .REF_DIV_MIN  (REF_DIV_MIN),
    .MAX_OUT_DIV  (MAX_OUT_DIV),
    .ERR_FRAC_BITS(ERR_FRAC_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .req_valid_i   (req_valid),
    .req_i         (req),
    .req_pop_o     (req_pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .list_cmd_o    (list_cmd),
    .list_stat_i   (list_stat),
    .sel_i         (sel),
    .rank_o        (rank_sel),
    .strobe        (strobe),
    .result_o      (result),
    .found_count_o (found_count_o)
  );

  // shared divider
  fnps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ranked setting list
  fnps_rank #(
    .LIST_DEPTH   (LIST_DEPTH),
    .ERR_FRAC_BITS(ERR_FRAC_BITS)
  ) u_rank (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .good_err_hz_i (cfg_q.good_err_hz),
    .cmd_i         (list_cmd),
    .rank_i        (rank_sel),
    .stat_o        (list_stat),
    .sel_o         (sel)
  );

  assign int_value_o    = result.int_value;
  assign frac_value_o   = result.frac_value;
  assign modulus_o      = result.modulus;
  assign ref_div_o      = result.ref_div;
  assign out_div_log2_o = result.out_div_log2;
  assign band_div_o     = result.band_div;
  assign freq_error_o   = result.freq_error;

endmodule

FILE: tb/tb_frac_n_pll_setting_search.sv
module tb_frac_n_pll_setting_search;
  import fnps_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 64'd60_000_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [31:0]           target_hz_i = '0;
  logic [3:0]            rank_i = '0;
  logic                  strobe;
  logic [15:0]           int_value_o;
  logic [11:0]           frac_value_o;
  logic [11:0]           modulus_o;
  logic [9:0]            ref_div_o;
  logic [2:0]            out_div_log2_o;
  logic [7:0]            band_div_o;
  logic [47:0]           freq_error_o;
  logic [3:0]            found_count_o;

  typedef struct packed {
    setting_t   pick;
    logic [3:0] count;
  } answer_t;

  cfg_t            pll_cfg;
  answer_t         pending_answers[$];
  int unsigned     mismatches = 0;
  longint unsigned cycles = 0;

  frac_n_pll_setting_search dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start, .busy,
    .target_hz_i, .rank_i, .strobe, .int_value_o, .frac_value_o, .modulus_o,
    .ref_div_o, .out_div_log2_o, .band_div_o, .freq_error_o, .found_count_o
  );

  // clock and cycle limit
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[frac_n_pll_setting_search] ERROR");
      $finish;
    end
  end

  // ranking rule between a new setting a and a kept setting b
  function automatic bit outranks(setting_t a, setting_t b);
    longint unsigned g;
    g = longint'(pll_cfg.good_err_hz) << 16;
    if (a.freq_error < g && b.freq_error < g) begin
      if (a.modulus > b.modulus) return 1'b1;
      if (a.modulus < b.modulus) return 1'b0;
    end
    return a.freq_error < b.freq_error;
  endfunction

  // full search for one target, returns the ranked pick and the kept count
  function automatic answer_t search_settings(logic [31:0] tgt, logic [3:0] rk);
    setting_t        kept_list[10];
    setting_t        cand;
    int unsigned     kept, pos, last, sel;
    longint unsigned den, odiv, lg, vco, rc, n, il, band;
    longint unsigned p, q, p1, q1, p2, q2, r, dd, a, nr, qn, pn;
    longint unsigned d2, aa, bb, diff, whole, rem, er;
    bit              ok;
    answer_t         ans;
    kept = 0;
    ans = '0;
    den = longint'(pll_cfg.ref_mhz) * HZ_PER_MHZ;
    if (den != 0) begin
      odiv = 1;
      lg = 0;
      while (odiv <= 16) begin
        vco = odiv * tgt;
        if (!(vco < longint'(pll_cfg.vco_min_mhz) * HZ_PER_MHZ ||
              vco > longint'(pll_cfg.vco_max_mhz) * HZ_PER_MHZ)) begin
          for (rc = 1; rc <= pll_cfg.ref_div_max; rc++) begin
            n = tgt * rc * odiv;
            band = (10 * longint'(pll_cfg.ref_mhz)) / rc;
            if (band == 0) band = 1;
            if (band > 255) band = 255;
            cand = '0;
            cand.ref_div = rc[9:0];
            cand.out_div_log2 = lg[2:0];
            cand.band_div = band[7:0];
            ok = 1'b0;
            il = n / den;
            if (n % den == 0 && il >= pll_cfg.int_min && il <= pll_cfg.int_max) begin
              cand.int_value = il[15:0];
              cand.modulus = pll_cfg.mod_max;
              ok = 1'b1;
            end else begin
              // continued fraction, last convergent within the modulus bound
              p1 = n / den; q1 = 1; p2 = 1; q2 = 0; r = n % den; dd = den;
              p = p1; q = q1;
              while (r != 0) begin
                a = dd / r;
                nr = dd % r;
                qn = a * q1 + q2;
                if (qn > pll_cfg.mod_max) break;
                pn = a * p1 + p2;
                p = pn; q = qn;
                p2 = p1; p1 = pn; q2 = q1; q1 = qn;
                dd = r;
                r = nr;
              end
              if (q >= 2 && q <= pll_cfg.mod_max) begin
                il = p / q;
                if (il >= pll_cfg.int_min && il <= pll_cfg.int_max) begin
                  d2 = q * rc * odiv;
                  aa = den * p;
                  bb = longint'(tgt) * d2;
                  diff = aa > bb ? aa - bb : bb - aa;
                  whole = diff / d2;
                  rem = diff % d2;
                  if (whole >= (64'd1 << 32)) er = 64'hFFFF_FFFF_FFFF;
                  else er = (whole << 16) + (rem << 16) / d2;
                  cand.int_value = il[15:0];
                  cand.frac_value = 12'(p % q);
                  cand.modulus = q[11:0];
                  cand.freq_error = er[47:0];
                  ok = 1'b1;
                end
              end
            end
            if (ok) begin
              pos = 0;
              while (pos < kept && !outranks(cand, kept_list[pos])) pos++;
              if (pos < 10) begin
                last = kept < 10 ? kept : 9;
                for (int unsigned i = last; i > pos; i--) kept_list[i] = kept_list[i-1];
                kept_list[pos] = cand;
                if (kept < 10) kept++;
              end
            end
          end
        end
        odiv = odiv * 2;
        lg++;
      end
    end
    if (kept != 0) begin
      sel = rk > kept - 1 ? kept - 1 : rk;
      ans.pick = kept_list[sel];
      ans.count = kept[3:0];
    end
    return ans;
  endfunction

  // register write, only while idle
  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_REF_DIV_MAX: pll_cfg.ref_div_max = value[9:0];
      REG_INT_MIN:     pll_cfg.int_min = value[15:0];
      REG_INT_MAX:     pll_cfg.int_max = value[15:0];
      REG_MOD_MAX:     pll_cfg.mod_max = value[11:0];
      REG_REF_MHZ:     pll_cfg.ref_mhz = value[7:0];
      REG_VCO_MIN:     pll_cfg.vco_min_mhz = value[12:0];
      REG_VCO_MAX:     pll_cfg.vco_max_mhz = value[12:0];
      default:         pll_cfg.good_err_hz = value[19:0];
    endcase
  endtask

  task automatic set_all(int unsigned rmax, int unsigned imin, int unsigned imax,
                         int unsigned mmax, int unsigned refm, int unsigned vmin,
                         int unsigned vmax, int unsigned gerr);
    write_reg(REG_REF_DIV_MAX, rmax);
    write_reg(REG_INT_MIN, imin);
    write_reg(REG_INT_MAX, imax);
    write_reg(REG_MOD_MAX, mmax);
    write_reg(REG_REF_MHZ, refm);
    write_reg(REG_VCO_MIN, vmin);
    write_reg(REG_VCO_MAX, vmax);
    write_reg(REG_GOOD_ERR, gerr);
  endtask

  // send one request item and record its expected answer
  task automatic send_request(logic [31:0] tgt, logic [3:0] rk);
    @(negedge clk_i);
    start <= 1'b1;
    target_hz_i <= tgt;
    rank_i <= rk;
    do @(posedge clk_i); while (busy);
    pending_answers.push_back(search_settings(tgt, rk));
  endtask

  task automatic idle_sender();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 2);
    repeat (len) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // wait until every answer is in
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // check each result against the oldest expected answer
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && strobe) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item");
      end else begin
        want = pending_answers.pop_front();
        if (int_value_o !== want.pick.int_value || frac_value_o !== want.pick.frac_value ||
            modulus_o !== want.pick.modulus || ref_div_o !== want.pick.ref_div ||
            out_div_log2_o !== want.pick.out_div_log2 ||
            band_div_o !== want.pick.band_div || freq_error_o !== want.pick.freq_error ||
            found_count_o !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp int %0d frac %0d mod %0d r %0d od %0d band %0d err %0h n %0d",
                     want.pick.int_value, want.pick.frac_value, want.pick.modulus,
                     want.pick.ref_div, want.pick.out_div_log2, want.pick.band_div,
                     want.pick.freq_error, want.count, " got %0d %0d %0d %0d %0d %0d %0h %0d",
                     int_value_o, frac_value_o, modulus_o, ref_div_o, out_div_log2_o,
                     band_div_o, freq_error_o, found_count_o);
        end
      end
    end
  end

  // defaults, with targets that leave every divider out of the vco range
  task automatic test_defaults();
    send_request(32'd0, 4'd0);
    send_request(32'd100_000_000, 4'd9);
    drain();
  endtask

  // integer mode, fractional mode, rank handling and odd corners
  task automatic test_directed();
    set_all(4, 0, 65535, 4095, 10, 0, 8000, 50);
    send_request(32'd100_000_000, 4'd0);
    send_request(32'd100_000_000, 4'd15);
    send_request(32'd0, 4'd0);
    send_request(32'd123_456_789, 4'd1);
    send_request(32'd333_333_333, 4'd9);
    drain();
    // pause with nothing outstanding, then integer values out of range
    write_reg(REG_INT_MAX, 5);
    send_request(32'd100_000_000, 4'd0);
    drain();
    write_reg(REG_INT_MAX, 65535);
    // modulus bound below two
    write_reg(REG_MOD_MAX, 1);
    send_request(32'd100_000_000, 4'd2);
    send_request(32'd123_456_789, 4'd0);
    drain();
    write_reg(REG_MOD_MAX, 0);
    send_request(32'd77_777_777, 4'd0);
    drain();
    // zero reference, then empty divider range
    set_all(3, 0, 65535, 4095, 0, 0, 8000, 0);
    send_request(32'd100_000_000, 4'd0);
    drain();
    set_all(0, 0, 65535, 4095, 250, 0, 8000, 1000000);
    send_request(32'd250_000_000, 4'd0);
    drain();
    // top ends of the fields
    set_all(2, 65535, 65535, 4095, 250, 8000, 8000, 1048575);
    send_request(32'hFFFF_FFFF, 4'd15);
    send_request(32'd500_000_000, 4'd0);
    drain();
    set_all(1023, 23, 65535, 4095, 1, 8000, 8000, 50);
    send_request(32'd1, 4'd0);
    drain();
    set_all(3, 0, 65535, 4095, 1, 0, 8000, 1048575);
    send_request(32'hFFFF_FFFF, 4'd3);
    send_request(32'd12_345_678, 4'd9);
    drain();
  endtask

  // random settings per phase, targets mostly inside the vco window
  task automatic test_random();
    int unsigned vmin, vmax, od;
    longint unsigned t;
    for (int ph = 0; ph < 10; ph++) begin
      vmin = $urandom_range(0, 7000);
      vmax = vmin + $urandom_range(0, 8000 - vmin);
      set_all($urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 4),
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 60),
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 65535,
              $urandom_range(0, 4) == 0 ? $urandom_range(0, 8) : $urandom_range(2, 4095),
              $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 250),
              vmin, vmax,
              $urandom_range(0, 1) ? $urandom_range(0, 1048575) : $urandom_range(0, 200));
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          t = $urandom();
        end else begin
          od = 1 << $urandom_range(0, 4);
          t = (longint'($urandom_range(vmin, vmax)) * 1000000 + $urandom_range(0, 999999)) / od;
          if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
        end
        send_request(t[31:0], 4'($urandom_range(0, 15)));
        idle_sender();
      end
      drain();
    end
  endtask

  initial begin
    pll_cfg.ref_div_max = 10'd1023;
    pll_cfg.int_min = 16'd23;
    pll_cfg.int_max = 16'd65535;
    pll_cfg.mod_max = 12'd4095;
    pll_cfg.ref_mhz = 8'd5;
    pll_cfg.vco_min_mhz = 13'd2200;
    pll_cfg.vco_max_mhz = 13'd4400;
    pll_cfg.good_err_hz = 20'd50;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(negedge clk_i);
    test_defaults();
    test_directed();
    test_random();
    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("[frac_n_pll_setting_search] OK");
    end else begin
      $display("[frac_n_pll_setting_search] ERROR");
    end
    $finish;
  end

endmodule
